// ===== hw/rtl/pld_pkg.sv =====
// Shared types, widths and constants for the limited-integral dead-band PID core.
package pld_pkg;

  localparam int unsigned ValW    = 16;  // Q7.8 values, gains, Q4.11 output
  localparam int unsigned ErrW    = 17;  // setpoint - measured, exact
  localparam int unsigned SumW    = 24;  // integral, Q15.8
  localparam int unsigned CountW  = 8;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned UFieldW = 15;  // unsigned config fields

  localparam int unsigned SettleSamplesDef = 10;
  localparam int unsigned DeadBandDef      = 0;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegGainP     = 3'd0;
  localparam logic [IdxW-1:0] RegGainI     = 3'd1;
  localparam logic [IdxW-1:0] RegGainD     = 3'd2;
  localparam logic [IdxW-1:0] RegSetpoint  = 3'd3;
  localparam logic [IdxW-1:0] RegEpsilon   = 3'd4;
  localparam logic [IdxW-1:0] RegStepLimit = 3'd5;
  localparam logic [IdxW-1:0] RegCeiling   = 3'd6;
  localparam logic [IdxW-1:0] RegFloor     = 3'd7;

  typedef struct packed {
    logic signed [ValW-1:0] gain_p;
    logic signed [ValW-1:0] gain_i;
    logic signed [ValW-1:0] gain_d;
    logic signed [ValW-1:0] setpoint;
    logic [UFieldW-1:0]     band_epsilon;
    logic [UFieldW-1:0]     sum_step_limit;
    logic [UFieldW-1:0]     out_ceiling;
    logic signed [ValW-1:0] out_floor;
  } cfg_t;

  // Terms handed from the state stage to the output stage
  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [SumW-1:0] error_sum;
    logic signed [ErrW-1:0] vel;
    logic                   settled;
  } term_t;

endpackage

// ===== hw/rtl/pld_regs.sv =====
// Configuration register file of the PID core.
module pld_regs
  import pld_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [ValW-1:0] wr_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        RegGainP:     cfg_d.gain_p         = wr_data_i;
        RegGainI:     cfg_d.gain_i         = wr_data_i;
        RegGainD:     cfg_d.gain_d         = wr_data_i;
        RegSetpoint:  cfg_d.setpoint       = wr_data_i;
        RegEpsilon:   cfg_d.band_epsilon   = wr_data_i[UFieldW-1:0];
        RegStepLimit: cfg_d.sum_step_limit = wr_data_i[UFieldW-1:0];
        RegCeiling:   cfg_d.out_ceiling    = wr_data_i[UFieldW-1:0];
        RegFloor:     cfg_d.out_floor      = wr_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.setpoint       <= '0;
      cfg_q.band_epsilon   <= '0;
      cfg_q.sum_step_limit <= 15'd13;
      cfg_q.out_ceiling    <= 15'h7fff;
      cfg_q.out_floor      <= 16'sh8000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/pld_state.sv =====
// Input register, integral / velocity / settle-count update and term register.
module pld_state
  import pld_pkg::*;
#(
  parameter int unsigned SETTLE_SAMPLES = SettleSamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ValW-1:0] in_meas_i,
  input  logic            in_clr_i,
  output logic            term_valid_o,
  input  logic            term_ready_i,
  output term_t           term_o
);

  logic                   in_valid_q;
  logic signed [ValW-1:0] meas_q;
  logic                   clr_q;

  logic                   term_valid_q;
  term_t                  term_q, term_d;

  logic signed [ValW-1:0]   last_q, last_d;
  logic                     first_q, first_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0]        count_q, count_d;

  logic                     advance;
  logic                     term_free;
  logic signed [ErrW-1:0]   err, eps, lim, add;
  logic signed [SumW-1:0]   sum0, base;
  logic signed [SumW+1:0]   sum_wide;
  logic                     in_band, settled;

  assign term_free    = !term_valid_q || term_ready_i;
  assign advance      = in_valid_q && term_free;
  assign in_ready_o   = !in_valid_q || term_free;
  assign term_valid_o = term_valid_q;
  assign term_o       = term_q;

  always_comb begin
    err  = ErrW'(cfg_i.setpoint) - ErrW'(meas_q);
    eps  = $signed({2'b00, cfg_i.band_epsilon});
    lim  = $signed({2'b00, cfg_i.sum_step_limit});
    sum0 = clr_q ? '0 : sum_q;
    base = sum0;
    add  = err;
    if (err >= eps) begin
      if (sum0 < 0) base = '0;
      if (err >= lim) add = lim;
    end else if (err <= -eps) begin
      if (sum0 > 0) base = '0;
      if (err <= -lim) add = -lim;
    end else begin
      base = '0;
      add  = '0;
    end
    sum_wide = (SumW+2)'(base) + (SumW+2)'(add);
    if (sum_wide > (SumW+2)'(signed'({1'b0, {(SumW-1){1'b1}}}))) begin
      sum_d = {1'b0, {(SumW-1){1'b1}}};
    end else if (sum_wide < -(SumW+2)'(signed'({2'b01, {(SumW-1){1'b0}}}))) begin
      sum_d = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end

    // Hold the count once settled; drop it on any out-of-band sample
    in_band = (err <= eps) && (err >= -eps);
    settled = 1'b0;
    count_d = count_q;
    if (in_band) begin
      if (count_q >= CountW'(SETTLE_SAMPLES)) settled = 1'b1;
      else count_d = count_q + 1'b1;
    end else begin
      count_d = '0;
    end

    last_d  = meas_q;
    first_d = 1'b0;

    term_d.err       = err;
    term_d.error_sum = sum_d;
    term_d.vel       = first_q ? '0 : ErrW'(meas_q) - ErrW'(last_q);
    term_d.settled   = settled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      term_valid_q <= 1'b0;
      last_q       <= '0;
      first_q      <= 1'b1;
      sum_q        <= '0;
      count_q      <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (term_free) term_valid_q <= in_valid_q;
      if (advance) begin
        last_q  <= last_d;
        first_q <= first_d;
        sum_q   <= sum_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      meas_q <= in_meas_i;
      clr_q  <= in_clr_i;
    end
    if (advance) term_q <= term_d;
  end

endmodule

// ===== hw/rtl/pld_out.sv =====
// Gain products, rounding, clamp, dead band and result register.
module pld_out
  import pld_pkg::*;
#(
  parameter int unsigned DEAD_BAND = DeadBandDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            term_valid_i,
  output logic            term_ready_o,
  input  term_t           term_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ValW-1:0] out_drive_o,
  output logic            out_settled_o
);

  localparam int unsigned ProdPW = ValW + ErrW;
  localparam int unsigned ProdIW = ValW + SumW;
  localparam int unsigned AccW   = ProdIW + 2;
  localparam int unsigned OW     = AccW - 5;

  logic                     out_valid_q;
  logic [ValW-1:0]          drive_q, drive_d;
  logic                     settled_q;

  logic signed [ProdPW-1:0] prod_p, prod_d;
  logic signed [ProdIW-1:0] prod_i;
  logic signed [AccW-1:0]   acc, rnd;
  logic signed [OW-1:0]     o, ceil_w, floor_w, db_w;

  assign term_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    prod_p  = term_i.err * cfg_i.gain_p;
    prod_i  = term_i.error_sum * cfg_i.gain_i;
    prod_d  = term_i.vel * cfg_i.gain_d;
    acc     = AccW'(prod_p) + AccW'(prod_i) - AccW'(prod_d);
    // Round half up to Q4.11: floor of (acc + 16) / 32
    rnd     = acc + AccW'(16);
    o       = $signed(rnd[AccW-1:5]);
    ceil_w  = $signed({{(OW-UFieldW){1'b0}}, cfg_i.out_ceiling});
    floor_w = OW'(cfg_i.out_floor);
    db_w    = $signed({{(OW-UFieldW){1'b0}}, UFieldW'(DEAD_BAND)});
    if (o > ceil_w) begin
      drive_d = ceil_w[ValW-1:0];
    end else if (o < floor_w) begin
      drive_d = floor_w[ValW-1:0];
    end else if (o > -db_w && o < db_w) begin
      drive_d = '0;
    end else begin
      drive_d = o[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (term_ready_o) begin
      out_valid_q <= term_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_ready_o && term_valid_i) begin
      drive_q   <= drive_d;
      settled_q <= term_i.settled;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_drive_o   = drive_q;
  assign out_settled_o = settled_q;

endmodule

// ===== hw/rtl/pid_limited_integral_deadband_core.sv =====
// Fixed-point PID core: input register, state update stage, product and clamp stage.
// An accepted input beat passes the input, term and result registers in turn to the output.
// Throughput: one beat per cycle; each stage advances whenever the next one has room,
// so a result waiting on the output register stalls the input once the stages behind it fill.
// Reset: asynchronous, active low; clears config to defaults, integral, count and
// last measurement, and marks the next sample as the first one (zero velocity).
module pid_limited_integral_deadband_core
  import pld_pkg::*;
#(
  parameter int unsigned SETTLE_SAMPLES = SettleSamplesDef,
  parameter int unsigned DEAD_BAND      = DeadBandDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0] cfg_data_i,
  // sample stream in
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // [15:0] measured
  input  logic            s_axis_tuser,   // [0] clear_integral
  // result stream out
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // [15:0] drive
  output logic            m_axis_tuser    // [0] settled
);

  cfg_t  cfg;
  term_t term;
  logic  term_valid, term_ready;

  assign cfg_ready_o = 1'b1;

  pld_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  pld_state #(
    .SETTLE_SAMPLES (SETTLE_SAMPLES)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_meas_i    (s_axis_tdata),
    .in_clr_i     (s_axis_tuser),
    .term_valid_o (term_valid),
    .term_ready_i (term_ready),
    .term_o       (term)
  );

  pld_out #(
    .DEAD_BAND (DEAD_BAND)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .term_valid_i  (term_valid),
    .term_ready_o  (term_ready),
    .term_i        (term),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_drive_o   (m_axis_tdata),
    .out_settled_o (m_axis_tuser)
  );

endmodule
